@@ src/mfr_pkg.sv @@
// shared constants and controller/datapath interface types for the multidrop frame receiver
`timescale 1ns / 1ps

package mfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int HDR_LEN     = 6;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int PTR_W       = $clog2(MAX_PAYLOAD);
    localparam int POS_W       = $clog2(HDR_LEN + MAX_PAYLOAD + 1);
    localparam int HDR_IDX_W   = $clog2(HDR_LEN);

    // header byte slots
    localparam int HDR_DEST = 0;
    localparam int HDR_SRC  = 1;
    localparam int HDR_SEQ  = 2;
    localparam int HDR_CMD  = 3;
    localparam int HDR_CHAN = 4;
    localparam int HDR_SIZE = 5;

    localparam logic [BYTE_W-1:0] BCAST_ADDR   = 8'hFF;
    localparam logic [BYTE_W-1:0] OWN_ADDR_RST = 8'd7;
    localparam int                ACK_BIT      = 7;

    typedef struct packed {
        logic take;     // input beat accepted this cycle
        logic rd_en;    // read payload store at current result index
        logic adv;      // step to next result
    } mfr_cmd_t;

    typedef struct packed {
        logic frame_end;  // current input beat is the checksum byte
        logic last_res;   // current result is the final one of the frame
    } mfr_sts_t;

endpackage

@@ src/mfr_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module mfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/mfr_ctrl.sv @@
// controller fsm: character intake, then one read and one result beat per payload byte (one for an empty payload)
`timescale 1ns / 1ps

module mfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  mfr_pkg::mfr_sts_t sts,
    output mfr_pkg::mfr_cmd_t cmd
);
    import mfr_pkg::*;

    localparam logic [1:0] ST_RX  = 2'd0;
    localparam logic [1:0] ST_RD  = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_RX:
            begin
                in_stall = 1'b0;
                cmd.take = in_valid;
                if (in_valid && sts.frame_end)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (sts.last_res)
                    begin
                        state_next = ST_RX;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_RX;
            end
        endcase
    end

endmodule

@@ src/mfr_dp.sv @@
// datapath: frame position, header bytes, running sum, payload store and result fields
`timescale 1ns / 1ps

module mfr_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mfr_pkg::BYTE_W-1:0]      cfg_wr_data,
    input  logic [mfr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                            address_mark,
    input  mfr_pkg::mfr_cmd_t               cmd,
    output mfr_pkg::mfr_sts_t               sts,
    output logic [mfr_pkg::BYTE_W-1:0]      dest_addr,
    output logic [mfr_pkg::BYTE_W-1:0]      src_addr,
    output logic [mfr_pkg::BYTE_W-1:0]      seq_id,
    output logic [mfr_pkg::BYTE_W-1:0]      cmd_byte,
    output logic [mfr_pkg::BYTE_W-1:0]      chan_num,
    output logic [mfr_pkg::LEN_W-1:0]       payload_len,
    output logic [mfr_pkg::PTR_W-1:0]       byte_index,
    output logic [mfr_pkg::BYTE_W-1:0]      payload_byte,
    output logic                            checksum_ok,
    output logic                            ack_requested,
    output logic                            last_of_frame
);
    import mfr_pkg::*;

    logic [BYTE_W-1:0] own_addr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sum_reg;
    logic [BYTE_W-1:0] sum_next;
    logic [BYTE_W-1:0] hdr_reg [HDR_LEN];
    logic [BYTE_W-1:0] hdr_next [HDR_LEN];
    logic              chk_reg;
    logic              chk_next;
    logic [PTR_W-1:0]  k_reg;
    logic [PTR_W-1:0]  k_next;

    logic [POS_W-1:0]  pay_idx;
    logic              in_payload;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rd_data;
    logic [BYTE_W-1:0] size;

    assign size       = hdr_reg[HDR_SIZE];
    assign pay_idx    = pos_reg - POS_W'(HDR_LEN);
    assign in_payload = (BYTE_W'(pay_idx) < size);

    assign sts.frame_end = !address_mark && (pos_reg >= POS_W'(HDR_LEN)) && !in_payload;
    assign sts.last_res  = (size == '0) || ((BYTE_W'(k_reg) + 8'd1) == size);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= OWN_ADDR_RST;
            pos_reg      <= '0;
            sum_reg      <= '0;
            hdr_reg      <= '{default: '0};
            chk_reg      <= 1'b0;
            k_reg        <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                own_addr_reg <= cfg_wr_data;
            end
            pos_reg <= pos_next;
            sum_reg <= sum_next;
            hdr_reg <= hdr_next;
            chk_reg <= chk_next;
            k_reg   <= k_next;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        hdr_next = hdr_reg;
        chk_next = chk_reg;
        k_next   = k_reg;
        ram_we   = 1'b0;
        if (cmd.take)
        begin
            priority if (address_mark)
            begin
                // marked character restarts framing
                hdr_next           = '{default: '0};
                hdr_next[HDR_DEST] = rx_byte;
                sum_next           = rx_byte;
                pos_next = (rx_byte == own_addr_reg || rx_byte == BCAST_ADDR) ?
                           POS_W'(1) : '0;
            end
            else if (pos_reg == '0)
            begin
                // idle, unmarked character ignored
            end
            else if (pos_reg < POS_W'(HDR_LEN))
            begin
                hdr_next[pos_reg[HDR_IDX_W-1:0]] = rx_byte;
                sum_next = sum_reg + rx_byte;
                if (pos_reg == POS_W'(HDR_SIZE) && rx_byte > BYTE_W'(MAX_PAYLOAD))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else if (in_payload)
            begin
                ram_we   = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                // checksum byte closes the frame
                pos_next = '0;
                chk_next = (~sum_reg == rx_byte);
                k_next   = '0;
            end
        end
        if (cmd.adv)
        begin
            k_next = k_reg + PTR_W'(1);
        end
    end

    mfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (pay_idx[PTR_W-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd_en),
        .rd_addr (k_reg),
        .rd_data (ram_rd_data)
    );

    assign dest_addr     = hdr_reg[HDR_DEST];
    assign src_addr      = hdr_reg[HDR_SRC];
    assign seq_id        = hdr_reg[HDR_SEQ];
    assign cmd_byte      = hdr_reg[HDR_CMD];
    assign chan_num      = hdr_reg[HDR_CHAN];
    assign payload_len   = size[LEN_W-1:0];
    assign byte_index    = k_reg;
    assign payload_byte  = (size == '0) ? '0 : ram_rd_data;
    assign checksum_ok   = chk_reg;
    assign ack_requested = hdr_reg[HDR_CMD][ACK_BIT];
    assign last_of_frame = sts.last_res;

endmodule

@@ src/multidrop_frame_receiver_unit.sv @@
// after the checksum character beat, the fsm does a payload store read before offering the first result beat
// throughput: one character per cycle while a frame is received; each result
//   is a payload store read, then an output beat that out_stall can hold; input
//   is stalled during the result burst, so a frame of n payload bytes costs n+7
//   char beats plus a burst of max(n,1) results
// reset: async active low; idle, header and sum zero, own address 7, payload store not cleared
`timescale 1ns / 1ps

module multidrop_frame_receiver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mfr_pkg::BYTE_W-1:0]      cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mfr_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                            address_mark,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mfr_pkg::BYTE_W-1:0]      dest_addr,
    output logic [mfr_pkg::BYTE_W-1:0]      src_addr,
    output logic [mfr_pkg::BYTE_W-1:0]      seq_id,
    output logic [mfr_pkg::BYTE_W-1:0]      cmd_byte,
    output logic [mfr_pkg::BYTE_W-1:0]      chan_num,
    output logic [mfr_pkg::LEN_W-1:0]       payload_len,
    output logic [mfr_pkg::PTR_W-1:0]       byte_index,
    output logic [mfr_pkg::BYTE_W-1:0]      payload_byte,
    output logic                            checksum_ok,
    output logic                            ack_requested,
    output logic                            last_of_frame
);
    import mfr_pkg::*;

    mfr_cmd_t cmd;
    mfr_sts_t sts;

    mfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mfr_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .rx_byte       (rx_byte),
        .address_mark  (address_mark),
        .cmd           (cmd),
        .sts           (sts),
        .dest_addr     (dest_addr),
        .src_addr      (src_addr),
        .seq_id        (seq_id),
        .cmd_byte      (cmd_byte),
        .chan_num      (chan_num),
        .payload_len   (payload_len),
        .byte_index    (byte_index),
        .payload_byte  (payload_byte),
        .checksum_ok   (checksum_ok),
        .ack_requested (ack_requested),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ src/mfr_checker.sv @@
// port-level checker for the multidrop frame receiver, bound to the top level
`timescale 1ns / 1ps

module mfr_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [mfr_pkg::LEN_W-1:0]  payload_len,
    input logic [mfr_pkg::PTR_W-1:0]  byte_index,
    input logic [mfr_pkg::BYTE_W-1:0] payload_byte,
    input logic                       last_of_frame
);
    import mfr_pkg::*;

    // a waiting result beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // no new character is taken while a result burst is in progress
    a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during result burst");

    // between two results of one frame the store read cycle keeps input closed
    a_burst_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_frame |=> !out_valid && in_stall)
        else $error("burst did not continue after non-final result");

    // empty payload frames give exactly one zero result
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_len == '0 |->
            byte_index == '0 && payload_byte == '0 && last_of_frame)
        else $error("bad result for empty payload frame");

    // result index stays inside the payload
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_len != '0 |-> LEN_W'(byte_index) < payload_len)
        else $error("byte index beyond payload length");

endmodule

bind multidrop_frame_receiver_unit mfr_checker u_mfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_len   (payload_len),
    .byte_index    (byte_index),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame)
);
